### src/region_table_page_fault_translator_top_assert.svh
// assertion macros shared by the region table translator modules
`ifndef REGION_TABLE_PAGE_FAULT_TRANSLATOR_TOP_ASSERT_SVH
`define REGION_TABLE_PAGE_FAULT_TRANSLATOR_TOP_ASSERT_SVH

// condition holds at every edge outside reset
`define RTPF_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent in this cycle implies consequent in the next
`define RTPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/rtpf_pkg.sv
// shared types, codes and constants of the region table translator
package rtpf_pkg;

  localparam int DEF_MAX_REGIONS = 16;
  localparam int DEF_ADDR_BITS   = 32;

  localparam int FIELD_W    = 32;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int PAGE_BITS_W = 5;
  localparam int PADDR_W    = 1;
  localparam int PDATA_W    = 32;

  localparam logic [PAGE_BITS_W-1:0] PAGE_BITS_RESET = 5'd12;
  localparam logic [PADDR_W-1:0]     REG_PAGE_BITS   = 1'b0;

  localparam logic [MODE_W-1:0] MODE_ADD      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FAULT    = 2'd1;
  localparam int                MODE_ECHO_BIT = 1;

  localparam logic [STATUS_W-1:0] ST_MAPPED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_MAP = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ADDED  = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_PUT
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan;
    logic put;
  } cmd_t;

  typedef struct packed {
    logic is_fault;
    logic hit;
    logic scan_done;
    logic out_busy;
  } stat_t;

endpackage

### src/rtpf_ctrl.sv
// controller state machine: sequences load, execute, region scan and result transfer
module rtpf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  rtpf_pkg::stat_t st,
  output rtpf_pkg::cmd_t  cmd
);
  import rtpf_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = st.is_fault ? S_SCAN : S_PUT;
      end
      S_SCAN: begin
        if (st.hit || st.scan_done) state_next = S_PUT;
      end
      S_PUT: begin
        if (!st.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_EXEC: cmd.exec = 1'b1;
      S_SCAN: cmd.scan = 1'b1;
      S_PUT:  cmd.put  = !st.out_busy;
      default: cmd = '0;
    endcase
  end

  `include "region_table_page_fault_translator_top_assert.svh"

  `RTPF_ASSERT_ALWAYS(a_cmd_onehot, $onehot0({cmd.load, cmd.exec, cmd.scan, cmd.put}), "more than one command")
  `RTPF_ASSERT_NEXT(a_hit_to_put, state == S_SCAN && st.hit, state == S_PUT, "hit did not end scan")
  `RTPF_ASSERT_NEXT(a_nonfault_put, state == S_EXEC && !st.is_fault, state == S_PUT, "add or echo went to scan")
  `RTPF_ASSERT_ALWAYS(a_load_idle, !cmd.load || !in_stall, "load while stalled")

endmodule

### src/rtpf_datapath.sv
// datapath: item registers, region memory, first-match scan and output register
module rtpf_datapath #(
  parameter int MAX_REGIONS = rtpf_pkg::DEF_MAX_REGIONS,
  parameter int ADDR_BITS   = rtpf_pkg::DEF_ADDR_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rtpf_pkg::cmd_t                      cmd,
  output rtpf_pkg::stat_t                     st,
  input  logic [rtpf_pkg::PAGE_BITS_W-1:0]    page_bits,
  input  logic [rtpf_pkg::MODE_W-1:0]         mode,
  input  logic [rtpf_pkg::FIELD_W-1:0]        virt_addr,
  input  logic [rtpf_pkg::FIELD_W-1:0]        phys_addr,
  input  logic [rtpf_pkg::FIELD_W-1:0]        region_size,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rtpf_pkg::STATUS_W-1:0]       status,
  output logic [rtpf_pkg::FIELD_W-1:0]        phys_page,
  output logic [rtpf_pkg::FIELD_W-1:0]        send_base
);
  import rtpf_pkg::*;

  localparam int AW = ADDR_BITS;
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_REGIONS);
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [AW-1:0] ONE_A = AW'(1);

  // item registers, addresses held at the table width
  logic [MODE_W-1:0] mode_q;
  logic [AW-1:0]     va_q, pa_q, sz_q;

  logic [AW+FIELD_W-1:0] va_ext, pa_ext, sz_ext;
  assign va_ext = {{AW{1'b0}}, virt_addr};
  assign pa_ext = {{AW{1'b0}}, phys_addr};
  assign sz_ext = {{AW{1'b0}}, region_size};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= mode;
      va_q   <= va_ext[AW-1:0];
      pa_q   <= pa_ext[AW-1:0];
      sz_q   <= sz_ext[AW-1:0];
    end
  end

  // region memory
  logic [AW-1:0] mem_start [MAX_REGIONS];
  logic [AW-1:0] mem_end   [MAX_REGIONS];
  logic [AW-1:0] mem_off   [MAX_REGIONS];

  logic [CW-1:0] count, idx;
  logic          rd_valid;
  logic [AW-1:0] rd_start, rd_end, rd_off;

  logic is_echo, is_add, is_fault, full, mem_we, rd_en, hit, scan_done;

  assign is_echo  = mode_q[MODE_ECHO_BIT];
  assign is_add   = !is_echo && (mode_q == MODE_ADD);
  assign is_fault = !is_echo && (mode_q == MODE_FAULT);
  assign full     = (count >= MAX_C);
  assign mem_we   = cmd.exec && is_add && !full;

  assign hit       = rd_valid && (va_q >= rd_start) && (va_q < rd_end);
  assign scan_done = !rd_valid && (idx >= count);
  assign rd_en     = cmd.scan && !hit && (idx < count);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_start[count[IW-1:0]] <= va_q;
      mem_end[count[IW-1:0]]   <= va_q + sz_q;
      mem_off[count[IW-1:0]]   <= pa_q - va_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_start <= mem_start[idx[IW-1:0]];
      rd_end   <= mem_end[idx[IW-1:0]];
      rd_off   <= mem_off[idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      idx      <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (mem_we) count <= count + ONE_C;
      if (cmd.exec) begin
        idx      <= '0;
        rd_valid <= 1'b0;
      end else if (cmd.scan) begin
        rd_valid <= rd_en;
        if (rd_en) idx <= idx + ONE_C;
      end
    end
  end

  // translated address aligned down to the page
  logic [AW-1:0] low_mask, xlat_page;
  assign low_mask  = (ONE_A << page_bits) - ONE_A;
  assign xlat_page = (va_q + rd_off) & ~low_mask;

  // pending result
  logic [STATUS_W-1:0] res_status;
  logic [AW-1:0]       res_page, res_sbase;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (is_echo) begin
        res_status <= ST_MAPPED;
        res_page   <= va_q;
        res_sbase  <= '0;
      end else if (is_add) begin
        res_status <= full ? ST_FULL : ST_ADDED;
        res_page   <= '0;
        res_sbase  <= '0;
      end else begin
        res_status <= ST_NO_MAP;
        res_page   <= '0;
        res_sbase  <= va_q;
      end
    end else if (cmd.scan && hit) begin
      res_status <= ST_MAPPED;
      res_page   <= xlat_page;
    end
  end

  // output register
  logic [AW+FIELD_W-1:0] page_ext, sbase_ext;
  assign page_ext  = {{FIELD_W{1'b0}}, res_page};
  assign sbase_ext = {{FIELD_W{1'b0}}, res_sbase};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.put) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      status    <= res_status;
      phys_page <= page_ext[FIELD_W-1:0];
      send_base <= sbase_ext[FIELD_W-1:0];
    end
  end

  assign st.is_fault  = is_fault;
  assign st.hit       = hit;
  assign st.scan_done = scan_done;
  assign st.out_busy  = out_valid && out_stall;

  `include "region_table_page_fault_translator_top_assert.svh"

  `RTPF_ASSERT_ALWAYS(a_count_bound, count <= MAX_C, "region count past table depth")
  `RTPF_ASSERT_ALWAYS(a_rd_after_issue, !rd_valid || (idx != '0), "read data without a read")
  `RTPF_ASSERT_ALWAYS(a_put_free, !cmd.put || !(out_valid && out_stall), "result over a waiting one")
  `RTPF_ASSERT_NEXT(a_add_counts, mem_we, count == $past(count) + ONE_C, "add did not bump count")

endmodule

### src/region_table_page_fault_translator_top.sv
// top level of the region table page fault translator
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------------------
//  in       | input     | in_valid / in_stall  | mode, virt_addr, phys_addr, region_size
//  out      | output    | out_valid / out_stall| status, phys_page, send_base
//  config   | input     | apb psel/penable     | page_bits at byte address 0
//
//  add and page request items pass through the execute and put states to a loaded output register
//  fault items also pass a scan state, which reads one region a cycle from
//  the region memory through its registered read port and stops at the first match
//  the next item is taken once the result sits in the output register, even while
//  that result still waits on out_stall; a stalled output holds the result in place
//  synchronous reset empties the table and sets page_bits to 12, no clearing pass
module region_table_page_fault_translator_top #(
  parameter int MAX_REGIONS = rtpf_pkg::DEF_MAX_REGIONS,
  parameter int ADDR_BITS   = rtpf_pkg::DEF_ADDR_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [rtpf_pkg::MODE_W-1:0]      mode,
  input  logic [rtpf_pkg::FIELD_W-1:0]     virt_addr,
  input  logic [rtpf_pkg::FIELD_W-1:0]     phys_addr,
  input  logic [rtpf_pkg::FIELD_W-1:0]     region_size,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rtpf_pkg::STATUS_W-1:0]    status,
  output logic [rtpf_pkg::FIELD_W-1:0]     phys_page,
  output logic [rtpf_pkg::FIELD_W-1:0]     send_base,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rtpf_pkg::PADDR_W-1:0]     paddr,
  input  logic [rtpf_pkg::PDATA_W-1:0]     pwdata,
  output logic [rtpf_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);
  import rtpf_pkg::*;

  logic [PAGE_BITS_W-1:0] page_bits;
  cmd_t  cmd;
  stat_t st;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_bits <= PAGE_BITS_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == REG_PAGE_BITS)) begin
      page_bits <= pwdata[PAGE_BITS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_PAGE_BITS) prdata[PAGE_BITS_W-1:0] = page_bits;
  end

  rtpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  rtpf_datapath #(
    .MAX_REGIONS (MAX_REGIONS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .page_bits   (page_bits),
    .mode        (mode),
    .virt_addr   (virt_addr),
    .phys_addr   (phys_addr),
    .region_size (region_size),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .phys_page   (phys_page),
    .send_base   (send_base)
  );

endmodule
